FILE: hw/rtl/dat_pkg.sv
// Package with the shared types, codes and helpers of the device association table.
`default_nettype none

package dat_pkg;

  // Entry indexes are carried at the width of the largest supported table.
  localparam int unsigned IDX_W = 8;
  localparam int unsigned SHORT_W = 6;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SHORT_W-1:0] short_t;

  // Operation codes.
  localparam logic [1:0] FUNC_ASSOC = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Status codes.
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  // Short addresses count from one so that zero means "none".
  localparam logic [IDX_W:0] SHORT_BASE = (IDX_W + 1)'(16'h0001);

  // Request transaction.
  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] device_address;
    logic [7:0]  device_kind;
    logic [7:0]  signal_level;
  } in_t;

  // Response transaction.
  typedef struct packed {
    logic [1:0]   status;
    short_t       short_address;
    logic [7:0]   found_kind;
    logic [7:0]   found_level;
  } out_t;

  // Search token that walks the row of entries, one entry per cycle.
  typedef struct packed {
    logic       active;
    logic       hit;
    idx_t       hit_idx;
    logic [7:0] hit_kind;
    logic [7:0] hit_level;
    logic       free;
    idx_t       free_idx;
  } probe_t;

  // Update broadcast to every entry.
  typedef struct packed {
    logic       en;
    logic       clear;
    idx_t       idx;
    logic [7:0] kind;
    logic [7:0] level;
  } wr_t;

  // Entry index plus one, kept to the width of the short address field.
  function automatic short_t short_of(idx_t idx);
    logic [IDX_W:0] sum;
    sum = {1'b0, idx} + SHORT_BASE;
    return sum[SHORT_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/device_association_table.sv
// Top level of the device association table.
// The table holds TABLE_ENTRIES associations in a row of entry cells. Every request
// (associate, lookup, clear) launches a search token that steps through one entry per
// cycle, so the length of the entry row sets the time from acceptance to its response.
// One request is in flight at a time; a new request is taken as soon as the previous
// response has been loaded into the output register, even while that response is still
// stalled.
// A new association and a clear are applied in the cycle the response is produced.
`default_nettype none

module device_association_table #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire dat_pkg::in_t in_data_i,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output dat_pkg::out_t     out_data_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state_q;
  logic [1:0]           state_d;
  logic                 in_fire;
  logic                 launch_q;
  logic                 resp_fire;
  dat_pkg::in_t         req_q;
  dat_pkg::probe_t      done_q;
  dat_pkg::probe_t      chain [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES:0] active_vec;
  dat_pkg::wr_t         wr;
  dat_pkg::out_t        resp;
  dat_pkg::out_t        out_q;
  logic                 out_valid_q;

  assign in_fire    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign resp_fire  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Request register, and the token launch in the cycle after acceptance.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
    end else begin
      launch_q <= in_fire;
    end
  end

  always_comb begin
    chain[0]        = '0;
    chain[0].active = launch_q;
  end

  // Row of entry cells.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_entry
    dat_cell #(
      .ENTRY_IDX(i)
    ) u_entry (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .addr_i (req_q.device_address),
      .wr_i   (wr),
      .probe_i(chain[i]),
      .probe_o(chain[i+1])
    );
  end

  for (genvar i = 0; i <= TABLE_ENTRIES; i++) begin : g_active
    assign active_vec[i] = chain[i].active;
  end

  // Sequencer: idle, token walking, response pending.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (chain[TABLE_ENTRIES].active) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (resp_fire) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the token when it leaves the last entry.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_WALK) && chain[TABLE_ENTRIES].active) begin
      done_q <= chain[TABLE_ENTRIES];
    end
  end

  // Table update: fill the first free entry on a new association, or empty the table.
  always_comb begin
    wr       = '0;
    wr.idx   = done_q.free_idx;
    wr.kind  = req_q.device_kind;
    wr.level = req_q.signal_level;
    if (resp_fire) begin
      wr.en    = (req_q.func == dat_pkg::FUNC_ASSOC) && !done_q.hit && done_q.free;
      wr.clear = (req_q.func == dat_pkg::FUNC_CLEAR);
    end
  end

  // Response fields from the search result.
  always_comb begin
    resp = '0;
    case (req_q.func)
      dat_pkg::FUNC_ASSOC: begin
        if (done_q.hit) begin
          resp.short_address = dat_pkg::short_of(done_q.hit_idx);
        end else if (done_q.free) begin
          resp.short_address = dat_pkg::short_of(done_q.free_idx);
        end else begin
          resp.status = dat_pkg::STATUS_FULL;
        end
      end
      dat_pkg::FUNC_LOOKUP: begin
        if (done_q.hit) begin
          resp.short_address = dat_pkg::short_of(done_q.hit_idx);
          resp.found_kind    = done_q.hit_kind;
          resp.found_level   = done_q.hit_level;
        end else begin
          resp.status = dat_pkg::STATUS_NOT_FOUND;
        end
      end
      dat_pkg::FUNC_CLEAR: begin
        resp.status = dat_pkg::STATUS_OK;
      end
      default: begin
        resp.status = dat_pkg::STATUS_NOT_FOUND;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_fire) begin
      out_q <= resp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // At most one search token is in flight anywhere in the row.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(active_vec))
    else $error("more than one search token in the entry row");

  // A token only leaves the row while a request is being walked.
  a_tail_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[TABLE_ENTRIES].active |-> (state_q == ST_WALK))
    else $error("search token left the row outside a walk");

  // A fill and a clear never happen together, and a fill never follows a hit.
  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (!wr.clear && !done_q.hit && resp_fire))
    else $error("table update without a matching response");

  // A response taken from a completed walk is loaded into the output register and the sequencer returns to idle.
  a_resp_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_fire |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("response register not loaded after a completed walk");

endmodule

`default_nettype wire

FILE: hw/rtl/dat_cell.sv
// One entry of the association table with its stage of the search chain.
`default_nettype none

module dat_cell #(
  parameter int unsigned ENTRY_IDX = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [63:0]     addr_i,
  input  wire dat_pkg::wr_t    wr_i,
  input  wire dat_pkg::probe_t probe_i,
  output dat_pkg::probe_t      probe_o
);

  localparam dat_pkg::idx_t MyIdx = dat_pkg::idx_t'(ENTRY_IDX);

  logic            valid_q;
  logic [63:0]     address_q;
  logic [7:0]      kind_q;
  logic [7:0]      level_q;
  logic            match;
  logic            sel;
  dat_pkg::probe_t probe_d;
  dat_pkg::probe_t probe_q;

  // Only valid entries can match the searched address.
  assign match = valid_q && (address_q == addr_i);
  assign sel   = wr_i.en && (wr_i.idx == MyIdx);

  // Record the first hit and the first free entry seen by the token.
  always_comb begin
    probe_d = probe_i;
    if (probe_i.active && !probe_i.hit && match) begin
      probe_d.hit       = 1'b1;
      probe_d.hit_idx   = MyIdx;
      probe_d.hit_kind  = kind_q;
      probe_d.hit_level = level_q;
    end
    if (probe_i.active && !probe_i.free && !valid_q) begin
      probe_d.free     = 1'b1;
      probe_d.free_idx = MyIdx;
    end
  end

  // Hand the token to the next entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  // Valid bit: cleared by reset or a clear, set when this entry is filled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i.clear) begin
      valid_q <= 1'b0;
    end else if (sel) begin
      valid_q <= 1'b1;
    end
  end

  // Entry contents are only read while the entry is valid.
  always_ff @(posedge clk_i) begin
    if (sel) begin
      address_q <= addr_i;
      kind_q    <= wr_i.kind;
      level_q   <= wr_i.level;
    end
  end

  assign probe_o = probe_q;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for the device association table.
module tb;

  localparam int TABLE_SIZE = 32;
  // The block ignores this operation code and answers "not found".
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_ITEMS = 250;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  dat_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  dat_pkg::out_t out_data_o;

  // Requests waiting to be driven and responses predicted for accepted requests.
  dat_pkg::in_t pending_requests[$];
  dat_pkg::out_t expected_responses[$];

  // Shadow copy of the association table.
  logic table_valid[TABLE_SIZE];
  logic [63:0] table_addr[TABLE_SIZE];
  logic [7:0] table_kind[TABLE_SIZE];
  logic [7:0] table_level[TABLE_SIZE];

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served;
  int hold_count;
  int mismatches = 0;
  int idle_cycles = 0;

  device_association_table #(
    .TABLE_ENTRIES(TABLE_SIZE)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Empties the shadow table, as reset and the clear operation do.
  function automatic void clear_entries();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      table_valid[i] = 1'b0;
      table_addr[i] = '0;
      table_kind[i] = '0;
      table_level[i] = '0;
    end
  endfunction

  // Applies one request to the shadow table and returns the response it must produce.
  function automatic dat_pkg::out_t predict_response(dat_pkg::in_t req);
    dat_pkg::out_t rsp;
    int hit;
    int slot;
    rsp = '0;
    rsp.status = dat_pkg::STATUS_OK;
    hit = -1;
    slot = -1;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      if (hit < 0 && table_valid[i] && table_addr[i] == req.device_address) hit = i;
      if (slot < 0 && !table_valid[i]) slot = i;
    end
    case (req.func)
      dat_pkg::FUNC_ASSOC: begin
        if (hit >= 0) begin
          rsp.short_address = dat_pkg::short_t'(hit + 1);
        end else if (slot >= 0) begin
          table_valid[slot] = 1'b1;
          table_addr[slot] = req.device_address;
          table_kind[slot] = req.device_kind;
          table_level[slot] = req.signal_level;
          rsp.short_address = dat_pkg::short_t'(slot + 1);
        end else begin
          rsp.status = dat_pkg::STATUS_FULL;
        end
      end
      dat_pkg::FUNC_LOOKUP: begin
        if (hit >= 0) begin
          rsp.short_address = dat_pkg::short_t'(hit + 1);
          rsp.found_kind = table_kind[hit];
          rsp.found_level = table_level[hit];
        end else begin
          rsp.status = dat_pkg::STATUS_NOT_FOUND;
        end
      end
      dat_pkg::FUNC_CLEAR: clear_entries();
      default: rsp.status = dat_pkg::STATUS_NOT_FOUND;
    endcase
    return rsp;
  endfunction

  // Addresses lean toward zero, all ones and single set bits.
  function automatic logic [63:0] rand_address();
    logic [63:0] a;
    case ($urandom_range(0, 15))
      0: a = '0;
      1: a = '1;
      2: a = 64'd1 << $urandom_range(0, 63);
      default: a = {$urandom, $urandom};
    endcase
    return a;
  endfunction

  task automatic queue_request(input logic [1:0] func, input logic [63:0] addr,
                               input logic [7:0] kind, input logic [7:0] level);
    dat_pkg::in_t req;
    req.func = func;
    req.device_address = addr;
    req.device_kind = kind;
    req.signal_level = level;
    pending_requests.push_back(req);
  endtask

  // Random sessions over a small address pool, so that associations hit, lookups
  // find entries and the table runs full. A fill session associates more addresses
  // than the table holds before it turns to the random mix.
  task automatic queue_random(input int count);
    logic [63:0] pool[64];
    int pool_size;
    int length;
    int made;
    int roll;
    bit fill;
    made = 0;
    fill = 1'b1;
    while (made < count) begin
      pool_size = fill ? 48 : $urandom_range(4, 48);
      for (int i = 0; i < pool_size; i++) pool[i] = rand_address();
      if (fill || $urandom_range(0, 9) < 5) begin
        queue_request(dat_pkg::FUNC_CLEAR, rand_address(), 8'($urandom), 8'($urandom));
        made++;
      end
      if (fill) begin
        for (int i = 0; i < 34; i++)
          queue_request(dat_pkg::FUNC_ASSOC, pool[i], 8'($urandom), 8'($urandom));
        made += 34;
      end
      length = $urandom_range(20, 80);
      for (int i = 0; i < length; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 50)
          queue_request(dat_pkg::FUNC_ASSOC, pool[$urandom_range(0, pool_size - 1)],
                        8'($urandom), 8'($urandom));
        else if (roll < 85)
          queue_request(dat_pkg::FUNC_LOOKUP, (roll % 7 == 0) ? rand_address() :
                        pool[$urandom_range(0, pool_size - 1)], 8'($urandom), 8'($urandom));
        else if (roll < 90)
          queue_request(FUNC_UNUSED, rand_address(), 8'($urandom), 8'($urandom));
        else if (roll < 93)
          queue_request(dat_pkg::FUNC_CLEAR, rand_address(), 8'($urandom), 8'($urandom));
        else
          queue_request(dat_pkg::FUNC_ASSOC, rand_address(), 8'($urandom), 8'($urandom));
      end
      made += length;
      fill = ($urandom_range(0, 3) == 0);
    end
  endtask

  // Returns once every queued request has been accepted and answered.
  task automatic wait_drained();
    while (pending_requests.size() != 0 || in_valid_i || expected_responses.size() != 0)
      @(negedge clk_i);
  endtask

  // Request driver; the response for each accepted transaction is predicted here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_responses.push_back(predict_response(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= pending_requests.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Response stall, with a long hold-off whenever one is requested.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_served <= 0;
      hold_count <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_count <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_count != 0) begin
      hold_count <= hold_count - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Response monitor: each accepted transaction is checked against the oldest prediction.
  always @(posedge clk_i) begin
    dat_pkg::out_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_responses.size() == 0) begin
        $error("unexpected response: status %0d short_address %0d",
               out_data_o.status, out_data_o.short_address);
        mismatches++;
      end else begin
        exp_rsp = expected_responses.pop_front();
        if (out_data_o.status !== exp_rsp.status) begin
          $error("status: expected %0d, got %0d", exp_rsp.status, out_data_o.status);
          mismatches++;
        end
        if (out_data_o.short_address !== exp_rsp.short_address) begin
          $error("short_address: expected %0d, got %0d",
                 exp_rsp.short_address, out_data_o.short_address);
          mismatches++;
        end
        if (out_data_o.found_kind !== exp_rsp.found_kind) begin
          $error("found_kind: expected %0d, got %0d", exp_rsp.found_kind, out_data_o.found_kind);
          mismatches++;
        end
        if (out_data_o.found_level !== exp_rsp.found_level) begin
          $error("found_level: expected %0d, got %0d",
                 exp_rsp.found_level, out_data_o.found_level);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither side completes a transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    clear_entries();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed transactions without idling: an empty table must not match address
    // zero, then hits, repeats, extreme fields, the unused code and a clear.
    queue_request(dat_pkg::FUNC_LOOKUP, 64'd0, 8'h00, 8'h00);
    queue_request(dat_pkg::FUNC_ASSOC, 64'd0, 8'h00, 8'h00);
    queue_request(dat_pkg::FUNC_LOOKUP, 64'd0, 8'hFF, 8'hFF);
    queue_request(dat_pkg::FUNC_ASSOC, '1, 8'hFF, 8'hFF);
    queue_request(dat_pkg::FUNC_ASSOC, '1, 8'h12, 8'h34);
    queue_request(dat_pkg::FUNC_LOOKUP, '1, 8'h00, 8'h00);
    queue_request(dat_pkg::FUNC_LOOKUP, 64'h8000_0000_0000_0000, 8'h00, 8'h00);
    queue_request(FUNC_UNUSED, '1, 8'hFF, 8'hFF);
    queue_request(dat_pkg::FUNC_LOOKUP, '1, 8'h00, 8'h00);
    queue_request(dat_pkg::FUNC_ASSOC, 64'h0000_0000_0000_0000, 8'h77, 8'h88);
    queue_request(dat_pkg::FUNC_CLEAR, '1, 8'hFF, 8'hFF);
    queue_request(dat_pkg::FUNC_LOOKUP, '1, 8'h00, 8'h00);
    queue_request(dat_pkg::FUNC_LOOKUP, 64'd0, 8'h00, 8'h00);
    queue_request(dat_pkg::FUNC_ASSOC, 64'h5555_5555_5555_5555, 8'hAA, 8'h55);
    queue_request(dat_pkg::FUNC_ASSOC, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 8'hAA);
    queue_request(dat_pkg::FUNC_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 8'h00, 8'h00);
    queue_request(dat_pkg::FUNC_LOOKUP, 64'h5555_5555_5555_5555, 8'hFF, 8'hFF);
    queue_request(FUNC_UNUSED, 64'd0, 8'h00, 8'h00);
    queue_request(dat_pkg::FUNC_ASSOC, 64'h5555_5555_5555_5555, 8'h00, 8'h00);
    queue_request(dat_pkg::FUNC_CLEAR, 64'd0, 8'h00, 8'h00);
    // Hold responses back while requests keep coming, so the input stalls.
    hold_requests++;
    wait_drained();

    queue_random(PHASE_ITEMS);
    wait_drained();

    sender_idle_pct = 81;
    queue_random(PHASE_ITEMS);
    wait_drained();

    sender_idle_pct = 0;
    recv_stall_pct = 81;
    queue_random(PHASE_ITEMS);
    wait_drained();

    sender_idle_pct = 8;
    recv_stall_pct = 8;
    queue_random(PHASE_ITEMS);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && expected_responses.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: device_association_table.f
hw/rtl/dat_pkg.sv
hw/rtl/dat_cell.sv
hw/rtl/device_association_table.sv
tb/tb.sv
